@@ rtl/skhd_pkg.sv @@
`timescale 1ns / 1ps
package skhd_pkg;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_FETCH  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_USED    = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  localparam int unsigned HashMul = 131;

  // bucket count, a power of two so the low hash bits pick the bucket
  localparam int unsigned Buckets = 1024;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] key_char;
    logic       key_last;
    logic [9:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] found_number;
    logic [6:0] out_char;
    logic       out_last;
  } rsp_t;

endpackage

@@ rtl/skhd_hash.sv @@
`timescale 1ns / 1ps
// running polynomial hash, one character per update
module skhd_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,
  input  logic        upd_i,
  input  logic [6:0]  char_i,
  output logic [63:0] hash_o
);
  logic [63:0] hash_q, hash_d;

  // h = h*131 + c, 131 = 128 + 2 + 1 as shifts and adds
  always_comb begin
    hash_d = hash_q;
    if (clr_i) begin
      hash_d = '0;
    end else if (upd_i) begin
      hash_d = (hash_q << 7) + (hash_q << 1) + hash_q + {57'd0, char_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;
endmodule

@@ rtl/string_key_hash_directory.sv @@
`timescale 1ns / 1ps
// Key directory. A key character item leaves busy low; so does an item
// answered at once (overlong key, entry number out of range). The last
// character of an insert keeps busy high while the key is copied into the
// character memory, or only while the slot flag is read when the slot is
// taken; a name lookup reads the bucket head, then per chain node its length
// and link and each compared character, through the single read port of the
// character memory; a fetch reads the entry and then streams its characters.
// After reset a clearing pass over the larger of the bucket count and
// MAX_ENTRIES empties the bucket heads and slot flags, with busy high.
// Results appear on rsp_o for one cycle marked by rsp_valid_o and cannot be
// held off.
module string_key_hash_directory #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned KEY_CHARS   = 19
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  skhd_pkg::req_t    req_i,
  output logic              rsp_valid_o,
  output skhd_pkg::rsp_t    rsp_o
);
  localparam int unsigned BUCKETS = skhd_pkg::Buckets;
  localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
  localparam int unsigned LW = $clog2(KEY_CHARS + 1);
  localparam int unsigned AW = $clog2(MAX_ENTRIES * KEY_CHARS);
  localparam int unsigned MD = MAX_ENTRIES * KEY_CHARS;
  localparam int unsigned CN = (BUCKETS > MAX_ENTRIES) ? BUCKETS : MAX_ENTRIES;
  localparam int unsigned CLW = $clog2(CN);
  localparam logic [NW-1:0] EMPTY = NW'(MAX_ENTRIES);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_HEADW = 4'd3;
  localparam logic [3:0] S_INS   = 4'd4;
  localparam logic [3:0] S_NODE  = 4'd5;
  localparam logic [3:0] S_NODEW = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_CMPW  = 4'd8;
  localparam logic [3:0] S_FCH   = 4'd9;
  localparam logic [3:0] S_FCHW  = 4'd10;
  localparam logic [3:0] S_FOUT  = 4'd11;

  // memories
  logic [6:0]    chars_mem [MD];
  logic [LW-1:0] len_mem   [MAX_ENTRIES];
  logic [NW-1:0] next_mem  [MAX_ENTRIES];
  logic [NW-1:0] head_mem  [BUCKETS];
  logic          used_mem  [MAX_ENTRIES];

  logic [3:0]     state_q;
  logic [CLW-1:0] clr_q;
  logic [6:0]    pend_q [KEY_CHARS];
  logic [LW-1:0] plen_q;
  logic          povf_q;
  logic [1:0]    op_q;
  logic [EW-1:0] num_q;
  logic [BW-1:0] bkt_q;
  logic [NW-1:0] node_q;
  logic [NW-1:0] steps_q;
  logic [LW-1:0] idx_q;
  logic [LW-1:0] flen_q;
  logic [AW-1:0] base_q;
  logic [6:0]    chr_rd_q;
  logic [LW-1:0] len_rd_q;
  logic [NW-1:0] next_rd_q;
  logic [NW-1:0] head_rd_q;
  logic          used_rd_q;
  logic          v_q;
  skhd_pkg::rsp_t rsp_q;

  logic [63:0] hash;
  logic        acc, keyreq, hupd, hclr;
  logic [EW-1:0] in_num;
  logic          num_ok;

  assign acc    = start && !busy;
  assign keyreq = acc && (req_i.req_type == skhd_pkg::REQ_INSERT ||
                          req_i.req_type == skhd_pkg::REQ_LOOKUP);
  assign hupd   = keyreq && (plen_q < LW'(KEY_CHARS));
  assign in_num = EW'(req_i.entry_number);
  assign num_ok = ({22'd0, req_i.entry_number} < 32'(MAX_ENTRIES));

  skhd_hash u_hash (
    .clk_i (clk_i), .rst_ni(rst_ni), .clr_i(hclr), .upd_i(hupd),
    .char_i(req_i.key_char), .hash_o(hash)
  );

  assign busy = (state_q != S_IDLE);

  // single-port memory access signals
  logic          cw_en, lw_en, hw_en, uw_en;
  logic [AW-1:0] c_addr;
  logic [6:0]    cw_data;
  logic [EW-1:0] l_addr;
  logic [BW-1:0] h_addr;
  logic [NW-1:0] hw_data;
  logic [EW-1:0] u_addr;
  logic          uw_data;

  always_ff @(posedge clk_i) begin
    if (cw_en) chars_mem[c_addr] <= cw_data;
    chr_rd_q <= chars_mem[c_addr];
  end
  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      len_mem[l_addr]  <= plen_q;
      next_mem[l_addr] <= head_rd_q;
    end
    len_rd_q  <= len_mem[l_addr];
    next_rd_q <= next_mem[l_addr];
  end
  always_ff @(posedge clk_i) begin
    if (hw_en) head_mem[h_addr] <= hw_data;
    head_rd_q <= head_mem[h_addr];
  end
  always_ff @(posedge clk_i) begin
    if (uw_en) used_mem[u_addr] <= uw_data;
    used_rd_q <= used_mem[u_addr];
  end

  // control and memory address selection
  always_comb begin
    cw_en = 1'b0; lw_en = 1'b0; hw_en = 1'b0; uw_en = 1'b0;
    c_addr = base_q + AW'(idx_q);
    cw_data = pend_q[idx_q[CW-1:0]];
    l_addr = node_q[EW-1:0];
    h_addr = bkt_q;
    hw_data = NW'(num_q);
    u_addr = num_q;
    uw_data = 1'b1;
    hclr = 1'b0;
    unique case (state_q)
      S_CLR: begin
        hw_en = (32'(clr_q) < BUCKETS); h_addr = clr_q[BW-1:0]; hw_data = EMPTY;
        uw_en = (32'(clr_q) < MAX_ENTRIES); u_addr = clr_q[EW-1:0]; uw_data = 1'b0;
      end
      S_INS: begin
        cw_en = (idx_q < plen_q);
        if (idx_q == plen_q) begin
          lw_en = 1'b1; l_addr = num_q; hw_en = 1'b1; uw_en = 1'b1;
        end
      end
      S_FCH: l_addr = num_q;
      // character read for fetch uses the address one ahead
      S_FOUT: c_addr = base_q + AW'(idx_q) + AW'(1);
      default: ;
    endcase
    // a finished key restarts the running hash
    if (keyreq && req_i.key_last) hclr = 1'b1;
  end

  // bucket index from the hash value including the current character
  logic [63:0] hash_now;
  assign hash_now = hupd ? ((hash << 7) + (hash << 1) + hash + {57'd0, req_i.key_char})
                         : hash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      plen_q  <= '0;
      povf_q  <= 1'b0;
      v_q     <= 1'b0;
    end else begin
      v_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLW'(CN - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (acc && req_i.req_type == skhd_pkg::REQ_FETCH) begin
            num_q  <= in_num;
            base_q <= AW'(in_num) * AW'(KEY_CHARS);
            idx_q  <= '0;
            if (!num_ok) begin
              v_q <= 1'b1;
              rsp_q <= '{skhd_pkg::ST_MISS, 10'd0, 7'd0, 1'b1};
            end else begin
              state_q <= S_FCH;
            end
          end else if (keyreq) begin
            if (req_i.key_last) begin
              op_q   <= req_i.req_type;
              num_q  <= in_num;
              base_q <= AW'(in_num) * AW'(KEY_CHARS);
              bkt_q  <= hash_now[BW-1:0];
              if (povf_q || !hupd) begin
                v_q <= 1'b1;
                rsp_q <= '{skhd_pkg::ST_TOOLONG, 10'd0, 7'd0, 1'b1};
                plen_q <= '0; povf_q <= 1'b0;
                for (int i = 0; i < int'(KEY_CHARS); i++) pend_q[i] <= '0;
              end else if (req_i.req_type == skhd_pkg::REQ_INSERT && !num_ok) begin
                v_q <= 1'b1;
                rsp_q <= '{skhd_pkg::ST_USED, 10'd0, 7'd0, 1'b1};
                plen_q <= '0; povf_q <= 1'b0;
                for (int i = 0; i < int'(KEY_CHARS); i++) pend_q[i] <= '0;
              end else begin
                pend_q[plen_q[CW-1:0]] <= req_i.key_char;
                plen_q <= plen_q + 1'b1;
                state_q <= S_HEAD;
              end
            end else if (hupd) begin
              pend_q[plen_q[CW-1:0]] <= req_i.key_char;
              plen_q <= plen_q + 1'b1;
            end else begin
              povf_q <= 1'b1;
            end
          end
        end
        S_HEAD: state_q <= S_HEADW;
        // bucket head and slot flag are ready
        S_HEADW: begin
          idx_q   <= '0;
          node_q  <= head_rd_q;
          steps_q <= '0;
          if (op_q == skhd_pkg::REQ_INSERT && used_rd_q) begin
            v_q <= 1'b1;
            rsp_q <= '{skhd_pkg::ST_USED, 10'd0, 7'd0, 1'b1};
            state_q <= S_IDLE;
            plen_q <= '0;
            for (int i = 0; i < int'(KEY_CHARS); i++) pend_q[i] <= '0;
          end else begin
            state_q <= (op_q == skhd_pkg::REQ_INSERT) ? S_INS : S_NODE;
          end
        end
        S_INS: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == plen_q) begin
            v_q <= 1'b1;
            rsp_q <= '{skhd_pkg::ST_OK, 10'(num_q), 7'd0, 1'b1};
            state_q <= S_IDLE;
            plen_q <= '0;
            for (int i = 0; i < int'(KEY_CHARS); i++) pend_q[i] <= '0;
          end
        end
        // chain walk: read length and link of the node
        S_NODE: begin
          if (node_q >= EMPTY || steps_q >= EMPTY) begin
            v_q <= 1'b1;
            rsp_q <= '{skhd_pkg::ST_MISS, 10'd0, 7'd0, 1'b1};
            state_q <= S_IDLE;
            plen_q <= '0;
            for (int i = 0; i < int'(KEY_CHARS); i++) pend_q[i] <= '0;
          end else begin
            base_q <= AW'(node_q[EW-1:0]) * AW'(KEY_CHARS);
            idx_q <= '0;
            state_q <= S_NODEW;
          end
        end
        S_NODEW: state_q <= S_CMP;
        S_CMP: begin
          if (len_rd_q != plen_q) begin
            node_q <= next_rd_q; steps_q <= steps_q + 1'b1; state_q <= S_NODE;
          end else if (idx_q == plen_q) begin
            v_q <= 1'b1;
            rsp_q <= '{skhd_pkg::ST_OK, 10'(node_q), 7'd0, 1'b1};
            state_q <= S_IDLE;
            plen_q <= '0;
            for (int i = 0; i < int'(KEY_CHARS); i++) pend_q[i] <= '0;
          end else begin
            state_q <= S_CMPW;
          end
        end
        S_CMPW: begin
          if (chr_rd_q != pend_q[idx_q[CW-1:0]]) begin
            node_q <= next_rd_q; steps_q <= steps_q + 1'b1; state_q <= S_NODE;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_CMP;
          end
        end
        S_FCH: state_q <= S_FCHW;
        S_FCHW: begin
          flen_q <= (len_rd_q > LW'(KEY_CHARS)) ? LW'(KEY_CHARS) : len_rd_q;
          if (!used_rd_q) begin
            v_q <= 1'b1;
            rsp_q <= '{skhd_pkg::ST_MISS, 10'd0, 7'd0, 1'b1};
            state_q <= S_IDLE;
          end else if (len_rd_q == '0) begin
            v_q <= 1'b1;
            rsp_q <= '{skhd_pkg::ST_OK, 10'(num_q), 7'd0, 1'b1};
            state_q <= S_IDLE;
          end else begin
            state_q <= S_FOUT;
          end
        end
        // one stored character per cycle, read address runs one ahead
        S_FOUT: begin
          idx_q <= idx_q + 1'b1;
          v_q <= 1'b1;
          rsp_q <= '{skhd_pkg::ST_OK, 10'(num_q), chr_rd_q, idx_q + 1'b1 == flen_q};
          if (idx_q + 1'b1 == flen_q) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid_o = v_q;
  assign rsp_o       = rsp_q;
endmodule

@@ rtl/skhd_checker.sv @@
`timescale 1ns / 1ps
// port-level checks
module skhd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           rsp_valid_o,
  input skhd_pkg::rsp_t rsp_o
);
  // results carry no character or entry number and are marked last unless ok
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != skhd_pkg::ST_OK |->
      rsp_o.out_char == '0 && rsp_o.found_number == '0 && rsp_o.out_last)
    else $error("failing status with payload");

  // a request that ends a result stream leaves busy
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.out_last |-> !busy)
    else $error("busy after last result");

  // mid-stream results keep the entry number and the stream has no gaps
  a_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.out_last |=> rsp_valid_o &&
      rsp_o.found_number == $past(rsp_o.found_number))
    else $error("fetch stream broken");
endmodule

bind string_key_hash_directory skhd_checker u_skhd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
);

@@ verif/string_key_hash_directory_tb.sv @@
`timescale 1ns / 1ps
module string_key_hash_directory_tb;

  localparam int unsigned NumEntries = 1024;
  localparam int unsigned NumBuckets = 1024;
  localparam int unsigned KeyMax     = 19;
  localparam logic [10:0] ChainEnd   = 11'd1024;

  typedef logic [6:0] key_q_t[$];

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  skhd_pkg::req_t req_i;
  logic rsp_valid_o;
  skhd_pkg::rsp_t rsp_o;

  // shadow copy of the directory
  logic [6:0]  dir_chars [NumEntries][KeyMax];
  logic [4:0]  dir_len   [NumEntries];
  logic        dir_used  [NumEntries];
  logic [10:0] dir_next  [NumEntries];
  logic [10:0] dir_head  [NumBuckets];
  logic [6:0]  cur_key   [KeyMax];
  logic [4:0]  cur_len;
  logic [63:0] cur_hash;
  logic        cur_overflow;
  logic [9:0]  used_numbers[$];

  skhd_pkg::rsp_t expected_rsps[$];
  int   mismatches;
  int   items_sent;
  int   rsps_seen;

  string_key_hash_directory DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic skhd_pkg::rsp_t make_rsp(logic [1:0] st, logic [9:0] num,
                                              logic [6:0] ch, logic lst);
    skhd_pkg::rsp_t r;
    r.status       = st;
    r.found_number = num;
    r.out_char     = ch;
    r.out_last     = lst;
    return r;
  endfunction

  function automatic bit key_equal(logic [9:0] node);
    if (dir_len[node] != cur_len) return 1'b0;
    for (int i = 0; i < cur_len; i++) begin
      if (dir_chars[node][i] != cur_key[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_current();
    for (int i = 0; i < KeyMax; i++) cur_key[i] = '0;
    cur_len      = '0;
    cur_hash     = '0;
    cur_overflow = 1'b0;
  endtask

  // work out the results one accepted item causes
  task automatic predict_directory(skhd_pkg::req_t r);
    logic [9:0]  bkt;
    logic [10:0] node;
    logic [4:0]  n;
    bit          hit;
    if (r.req_type == skhd_pkg::REQ_NONE) return;
    if (r.req_type == skhd_pkg::REQ_FETCH) begin
      if (!dir_used[r.entry_number]) begin
        expected_rsps.push_back(make_rsp(skhd_pkg::ST_MISS, '0, '0, 1'b1));
      end else begin
        n = dir_len[r.entry_number];
        for (int i = 0; i < n; i++) begin
          expected_rsps.push_back(make_rsp(skhd_pkg::ST_OK, r.entry_number,
                                           dir_chars[r.entry_number][i], i + 1 == n));
        end
      end
      return;
    end
    if (cur_len < KeyMax) begin
      cur_key[cur_len] = r.key_char;
      cur_len          = cur_len + 1;
      cur_hash         = cur_hash * skhd_pkg::HashMul + 64'(r.key_char);
    end else begin
      cur_overflow = 1'b1;
    end
    if (!r.key_last) return;
    bkt = cur_hash[9:0];
    if (cur_overflow) begin
      expected_rsps.push_back(make_rsp(skhd_pkg::ST_TOOLONG, '0, '0, 1'b1));
    end else if (r.req_type == skhd_pkg::REQ_INSERT) begin
      if (dir_used[r.entry_number]) begin
        expected_rsps.push_back(make_rsp(skhd_pkg::ST_USED, '0, '0, 1'b1));
      end else begin
        for (int i = 0; i < KeyMax; i++) dir_chars[r.entry_number][i] = cur_key[i];
        dir_len[r.entry_number]  = cur_len;
        dir_used[r.entry_number] = 1'b1;
        dir_next[r.entry_number] = dir_head[bkt];
        dir_head[bkt]            = {1'b0, r.entry_number};
        used_numbers.push_back(r.entry_number);
        expected_rsps.push_back(make_rsp(skhd_pkg::ST_OK, r.entry_number, '0, 1'b1));
      end
    end else begin
      node = dir_head[bkt];
      hit  = 1'b0;
      while (node != ChainEnd && !hit) begin
        if (key_equal(node[9:0])) hit = 1'b1;
        else node = dir_next[node[9:0]];
      end
      if (hit) expected_rsps.push_back(make_rsp(skhd_pkg::ST_OK, node[9:0], '0, 1'b1));
      else expected_rsps.push_back(make_rsp(skhd_pkg::ST_MISS, '0, '0, 1'b1));
    end
    clear_current();
  endtask

  // result checker
  always @(posedge clk_i) begin
    skhd_pkg::rsp_t want;
    if (rsp_valid_o) begin
      rsps_seen++;
      if (expected_rsps.size() == 0) begin
        $error("result with nothing expected: %p", rsp_o);
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, rsp_o.status);
          mismatches++;
        end
        if (rsp_o.found_number !== want.found_number) begin
          $error("found_number: expected %0d actual %0d", want.found_number,
                 rsp_o.found_number);
          mismatches++;
        end
        if (rsp_o.out_char !== want.out_char) begin
          $error("out_char: expected %0d actual %0d", want.out_char, rsp_o.out_char);
          mismatches++;
        end
        if (rsp_o.out_last !== want.out_last) begin
          $error("out_last: expected %0d actual %0d", want.out_last, rsp_o.out_last);
          mismatches++;
        end
      end
    end
  end

  // drive one item and hold it until accepted
  task automatic send_item(skhd_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_directory(r);
    items_sent++;
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // stream a key; mix picks random types for the leading characters
  task automatic send_key(logic [1:0] kind, key_q_t chars, logic [9:0] num, bit mix,
                          int pct);
    skhd_pkg::req_t r;
    for (int i = 0; i < chars.size(); i++) begin
      r.key_char     = chars[i];
      r.key_last     = (i == chars.size() - 1);
      r.req_type     = (mix && !r.key_last) ? 2'($urandom_range(1)) : kind;
      r.entry_number = r.key_last ? num : 10'($urandom);
      send_item(r);
      sender_gap(pct);
    end
  endtask

  task automatic send_fetch(logic [9:0] num);
    skhd_pkg::req_t r;
    r.req_type     = skhd_pkg::REQ_FETCH;
    r.key_char     = 7'($urandom);
    r.key_last     = 1'($urandom);
    r.entry_number = num;
    send_item(r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    key_q_t k;
    skhd_pkg::req_t r;
    // two keys landing in one bucket
    send_key(skhd_pkg::REQ_INSERT, '{7'd10, 7'd50}, 10'd5, 1'b0, 0);
    send_key(skhd_pkg::REQ_INSERT, '{7'd18, 7'd26}, 10'd1023, 1'b0, 0);
    send_key(skhd_pkg::REQ_LOOKUP, '{7'd10, 7'd50}, 10'd0, 1'b0, 0);
    // duplicate key, newest wins
    send_key(skhd_pkg::REQ_INSERT, '{7'd10, 7'd50}, 10'd0, 1'b0, 0);
    send_key(skhd_pkg::REQ_LOOKUP, '{7'd10, 7'd50}, 10'd0, 1'b0, 0);
    // occupied slot and character zero
    send_key(skhd_pkg::REQ_INSERT, '{7'd0}, 10'd5, 1'b0, 0);
    send_key(skhd_pkg::REQ_LOOKUP, '{7'd0}, 10'd0, 1'b0, 0);
    send_fetch(10'd1023);
    send_fetch(10'd7);
    // overlong key
    k = {};
    repeat (20) k.push_back(7'd127);
    send_key(skhd_pkg::REQ_INSERT, k, 10'd9, 1'b0, 0);
    // types mixed inside one key
    send_key(skhd_pkg::REQ_LOOKUP, '{7'd18, 7'd26}, 10'd0, 1'b1, 0);
    r = '{req_type: skhd_pkg::REQ_NONE, key_char: 7'd127, key_last: 1'b1,
          entry_number: 10'd1023};
    send_item(r);
    // full-length key
    k = {};
    for (int i = 0; i < KeyMax; i++) k.push_back(7'(i * 7 + 64));
    send_key(skhd_pkg::REQ_INSERT, k, 10'd512, 1'b0, 0);
    send_fetch(10'd512);
  endtask

  task automatic test_random(int n_items, int pct);
    key_q_t     k;
    logic [9:0] num;
    int         roll;
    int         stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      k    = {};
      if (roll < 35 && used_numbers.size() != 0) begin
        // lookup or duplicate insert of a stored key
        num = used_numbers[$urandom_range(used_numbers.size() - 1)];
        for (int i = 0; i < dir_len[num]; i++) k.push_back(dir_chars[num][i]);
        if (roll < 25) send_key(skhd_pkg::REQ_LOOKUP, k, 10'($urandom), roll < 5, pct);
        else send_key(skhd_pkg::REQ_INSERT, k, roll < 30 ? num : 10'($urandom), 1'b0,
                      pct);
      end else if (roll < 85) begin
        if ($urandom_range(9) == 0) roll = $urandom_range(20, 22);
        else if ($urandom_range(3) == 0) roll = KeyMax;
        else roll = $urandom_range(1, 6);
        repeat (roll) k.push_back(7'($urandom));
        send_key($urandom_range(1) ? skhd_pkg::REQ_INSERT : skhd_pkg::REQ_LOOKUP, k,
                 10'($urandom), $urandom_range(9) == 0, pct);
      end else if (roll < 95) begin
        if (used_numbers.size() != 0 && $urandom_range(1))
          num = used_numbers[$urandom_range(used_numbers.size() - 1)];
        else num = 10'($urandom);
        send_fetch(num);
        sender_gap(pct);
      end else begin
        send_item('{req_type: skhd_pkg::REQ_NONE, key_char: 7'($urandom),
                    key_last: 1'($urandom), entry_number: 10'($urandom)});
        sender_gap(pct);
      end
    end
  endtask

  // run end limit
  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int guard;
    for (int i = 0; i < NumEntries; i++) dir_used[i] = 1'b0;
    for (int i = 0; i < NumBuckets; i++) dir_head[i] = ChainEnd;
    clear_current();
    mismatches = 0;
    items_sent = 0;
    rsps_seen  = 0;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_drained();
    test_random(12, 0);
    test_random(12, 49);
    wait_drained();
    test_random(10, 0);
    test_random(10, 22);

    start <= 1'b0;
    guard = 0;
    while (expected_rsps.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
    $display("covered %0d items (inserts, lookups, fetches, overlong and ignored)",
             items_sent);
    $display("checked %0d results, %0d entries stored", rsps_seen, used_numbers.size());
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
